/* sv/float_vector_set_hash_top_assert.svh */
// Assertion macros for the set hash block.
`ifndef FLOAT_VECTOR_SET_HASH_TOP_ASSERT_SVH
`define FLOAT_VECTOR_SET_HASH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define FVSH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fvsh assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define FVSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fvsh assertion failed");
`else
`define FVSH_ASSERT_NOW(label, ante, cons)
`define FVSH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/fvsh_pkg.sv */
// Types, constants and helpers shared by the set hash block.
`timescale 1ns / 1ps
package fvsh_pkg;

  typedef logic [63:0] word_t;
  typedef logic [31:0] comp_t;

  localparam word_t MIX_MUL  = 64'hc6a4a7935bd1e995;
  localparam int    MIX_SHIFT = 47;
  // Seed offsets n * M modulo 2^64
  localparam word_t MIX_MUL3 = MIX_MUL + (MIX_MUL << 1);
  localparam word_t MIX_MUL4 = MIX_MUL << 2;

  // Multiply kinds, in order of use within a target
  localparam logic [1:0] K_WORD_MUL1 = 2'd0; // v *= M, then v ^= v >> R
  localparam logic [1:0] K_WORD_MUL2 = 2'd1; // v *= M, then h ^= v
  localparam logic [1:0] K_HASH_MUL  = 2'd2; // h *= M
  localparam logic [1:0] K_FINAL_MUL = 2'd3; // h *= M in finalization

  // Register index (address bit 2)
  localparam logic REG_COMPONENT_COUNT = 1'b0;

  // Both signed zeros fold to 0; everything else passes through.
  function automatic comp_t fold_comp(input comp_t bits);
    fold_comp = (bits[30:0] == 31'd0) ? 32'd0 : bits;
  endfunction

  function automatic word_t xorshift(input word_t x);
    xorshift = x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

/* sv/fvsh_in_if.sv */
// Request channel carrying one target per request.
`timescale 1ns / 1ps
interface fvsh_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_set;
  logic [31:0] comp_x;
  logic [31:0] comp_y;
  logic [31:0] comp_z;
  logic [31:0] comp_w;

  modport source (output valid, start_of_set, comp_x, comp_y, comp_z, comp_w,
                  input ready);
  modport sink   (input valid, start_of_set, comp_x, comp_y, comp_z, comp_w,
                  output ready);
endinterface

/* sv/fvsh_out_if.sv */
// Result channel carrying the running set hash.
`timescale 1ns / 1ps
interface fvsh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] set_hash;

  modport source (output valid, set_hash, input ready);
  modport sink   (input valid, set_hash, output ready);
endinterface

/* sv/float_vector_set_hash_top.sv */
// Set hash top level: chained Murmur64A-style hash over float targets.
`timescale 1ns / 1ps
`include "float_vector_set_hash_top_assert.svh"
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      start_of_set, comp_x, comp_y, comp_z, comp_w
//  out_ch    out  valid/ready      set_hash (64)
//  cfg_*     in   APB, pready=1    component_count at byte address 0
//
// One 32x32 multiplier does every 64-bit multiply by M as three partial products (lo*lo,
// lo*hi, hi*lo) in S_MUL, then a post step in S_POST that stores the product and does any
// xor/shift step. A target of n components needs 3n+1 multiplies, and in_ch.ready is high
// only while idle, so no new request is taken until the last one is done.
// The result sits in an output register; a stalled out_ch holds the last multiply's post
// cycle until it frees. Reset (rst_n, synchronous) clears the hash to 0, component_count to 4.
module float_vector_set_hash_top
  import fvsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fvsh_in_if.sink     in_ch,
  fvsh_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  localparam logic [1:0] PH_LO    = 2'd0;
  localparam logic [1:0] PH_CROSS = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  left_r, left_nxt;   // words still to load after the current one
  logic [2:0]  count_r;
  word_t       h_r, h_nxt;         // running hash between requests
  word_t       v_r, v_nxt;
  word_t       acc_r, acc_nxt;
  comp_t       words_r [3];
  comp_t       words_nxt [3];
  logic        out_valid_r, out_valid_nxt;
  word_t       out_hash_r, out_hash_nxt;

  logic        in_fire;
  logic        cfg_wr;
  word_t       mul_src;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  word_t       acc_mix;
  word_t       seed;
  logic        four_comps;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_COMPONENT_COUNT) ? {29'd0, count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd4;
    end else if (cfg_wr && cfg_paddr[2] == REG_COMPONENT_COUNT) begin
      count_r <= cfg_pwdata[2:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.set_hash = out_hash_r;

  assign four_comps = (count_r > 3'd3);
  assign seed       = in_ch.start_of_set ? 64'd0 : h_r;

  // ---------------------------------------------------------------- shared multiplier
  // Low 64 bits of src*M from lo*lo plus both cross terms in the upper half.
  assign mul_src = (kind_r == K_HASH_MUL || kind_r == K_FINAL_MUL) ? h_r : v_r;
  assign mul_a   = (ph_r == PH_LAST)  ? mul_src[63:32] : mul_src[31:0];
  assign mul_b   = (ph_r == PH_CROSS) ? MIX_MUL[63:32] : MIX_MUL[31:0];
  assign mul_p   = mul_a * mul_b;
  assign acc_mix = xorshift(acc_r);

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    words_nxt     = words_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          h_nxt        = seed ^ (four_comps ? MIX_MUL4 : MIX_MUL3);
          v_nxt        = {32'd0, fold_comp(in_ch.comp_x)};
          words_nxt[0] = fold_comp(in_ch.comp_y);
          words_nxt[1] = fold_comp(in_ch.comp_z);
          words_nxt[2] = fold_comp(in_ch.comp_w);
          left_nxt     = four_comps ? 2'd3 : 2'd2;
          kind_nxt     = K_WORD_MUL1;
          ph_nxt       = PH_LO;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        if (ph_r == PH_LO) begin
          acc_nxt = mul_p;
        end else begin
          acc_nxt[63:32] = acc_r[63:32] + mul_p[31:0];
        end
        if (ph_r == PH_LAST) begin
          ph_nxt    = PH_LO;
          state_nxt = S_POST;
        end else begin
          ph_nxt = ph_r + 2'd1;
        end
      end
      S_POST: begin
        state_nxt = S_MUL;
        unique case (kind_r)
          K_WORD_MUL1: begin
            v_nxt    = acc_mix;
            kind_nxt = K_WORD_MUL2;
          end
          K_WORD_MUL2: begin
            h_nxt    = h_r ^ acc_r;
            kind_nxt = K_HASH_MUL;
          end
          K_HASH_MUL: begin
            if (left_r == 2'd0) begin
              h_nxt    = acc_mix;
              kind_nxt = K_FINAL_MUL;
            end else begin
              h_nxt        = acc_r;
              v_nxt        = {32'd0, words_r[0]};
              words_nxt[0] = words_r[1];
              words_nxt[1] = words_r[2];
              left_nxt     = left_r - 2'd1;
              kind_nxt     = K_WORD_MUL1;
            end
          end
          K_FINAL_MUL: begin
            // wait here until the output register is free
            if (!out_valid_r || out_ch.ready) begin
              h_nxt         = acc_mix;
              out_hash_nxt  = acc_mix;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_POST;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_LO;
      kind_r      <= K_WORD_MUL1;
      left_r      <= 2'd0;
      h_r         <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      kind_r      <= kind_nxt;
      left_r      <= left_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    words_r    <= words_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // ---------------------------------------------------------------- checks
  `FVSH_ASSERT_NEXT(a_accept_starts_mul, in_fire, state_r == S_MUL && ph_r == PH_LO)
  `FVSH_ASSERT_NEXT(a_mul_ends_in_post, state_r == S_MUL && ph_r == PH_LAST, state_r == S_POST)
  `FVSH_ASSERT_NEXT(a_hash_holds_idle, state_r == S_IDLE && !in_fire, $stable(h_r))
  `FVSH_ASSERT_NOW(a_phase_in_range, state_r == S_MUL, ph_r != 2'd3)

endmodule
